### src/pcgbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcgbr_pkg;

    // LCG multiplier, split into halves for the 32x32 multiplier
    localparam logic [63:0] PCG_MULT    = 64'h5851_F42D_4C95_7F2D;
    localparam logic [31:0] PCG_MULT_LO = PCG_MULT[31:0];
    localparam logic [31:0] PCG_MULT_HI = PCG_MULT[63:32];

    // Draws allowed in one range request
    localparam int RETRY_LIMIT = 1024;

    // Divider width and configuration index width
    localparam int DIV_W     = 32;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_STATE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_STREAM = 1'b1;

    // Request codes
    localparam logic [1:0] REQ_RESEED = 2'd0;
    localparam logic [1:0] REQ_RAW    = 2'd1;
    localparam logic [1:0] REQ_RANGE  = 2'd2;

    // Micro-operations driving the datapath
    typedef enum logic [4:0] {
        OP_NOP,
        OP_FETCH,
        OP_EMIT,
        OP_RES_TRIV,
        OP_RESEED,
        OP_ADD_SEED,
        OP_MUL_LL,
        OP_MUL_LH,
        OP_MUL_HL,
        OP_MUL_FIN,
        OP_RES_ZERO,
        OP_RES_RAND,
        OP_BOUND,
        OP_DIV_THR,
        OP_DIV_WAIT,
        OP_SAVE_THR,
        OP_TRY,
        OP_DIV_RAND,
        OP_RES_MOD
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_RESEED,
        C_RAW,
        C_RANGE,
        C_REJECT
    } t_cond;

    localparam int PC_W     = 6;
    localparam int UC_DEPTH = 34;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    // Entry points of the program
    localparam logic [PC_W-1:0] ST_FETCH  = 6'd0;
    localparam logic [PC_W-1:0] ST_EMIT   = 6'd5;
    localparam logic [PC_W-1:0] ST_RESEED = 6'd6;
    localparam logic [PC_W-1:0] ST_RAW    = 6'd17;
    localparam logic [PC_W-1:0] ST_RANGE  = 6'd22;
    localparam logic [PC_W-1:0] ST_LOOP   = 6'd26;

    // Microcode program; a draw is the four steps MUL_LL .. MUL_FIN
    localparam t_uword UCODE [0:UC_DEPTH-1] = '{
        '{OP_FETCH,    C_NEXT,   ST_FETCH},   // 0  wait for a request
        '{OP_NOP,      C_RESEED, ST_RESEED},  // 1  dispatch
        '{OP_NOP,      C_RAW,    ST_RAW},     // 2
        '{OP_NOP,      C_RANGE,  ST_RANGE},   // 3
        '{OP_RES_TRIV, C_ALWAYS, ST_EMIT},    // 4  equal bounds or unused code
        '{OP_EMIT,     C_ALWAYS, ST_FETCH},   // 5  load output register
        '{OP_RESEED,   C_NEXT,   ST_FETCH},   // 6  reseed
        '{OP_MUL_LL,   C_NEXT,   ST_FETCH},   // 7
        '{OP_MUL_LH,   C_NEXT,   ST_FETCH},   // 8
        '{OP_MUL_HL,   C_NEXT,   ST_FETCH},   // 9
        '{OP_MUL_FIN,  C_NEXT,   ST_FETCH},   // 10
        '{OP_ADD_SEED, C_NEXT,   ST_FETCH},   // 11
        '{OP_MUL_LL,   C_NEXT,   ST_FETCH},   // 12
        '{OP_MUL_LH,   C_NEXT,   ST_FETCH},   // 13
        '{OP_MUL_HL,   C_NEXT,   ST_FETCH},   // 14
        '{OP_MUL_FIN,  C_NEXT,   ST_FETCH},   // 15
        '{OP_RES_ZERO, C_ALWAYS, ST_EMIT},    // 16
        '{OP_MUL_LL,   C_NEXT,   ST_FETCH},   // 17 raw draw
        '{OP_MUL_LH,   C_NEXT,   ST_FETCH},   // 18
        '{OP_MUL_HL,   C_NEXT,   ST_FETCH},   // 19
        '{OP_MUL_FIN,  C_NEXT,   ST_FETCH},   // 20
        '{OP_RES_RAND, C_ALWAYS, ST_EMIT},    // 21
        '{OP_BOUND,    C_NEXT,   ST_FETCH},   // 22 range request
        '{OP_DIV_THR,  C_NEXT,   ST_FETCH},   // 23
        '{OP_DIV_WAIT, C_NEXT,   ST_FETCH},   // 24
        '{OP_SAVE_THR, C_NEXT,   ST_FETCH},   // 25
        '{OP_MUL_LL,   C_NEXT,   ST_FETCH},   // 26 rejection loop
        '{OP_MUL_LH,   C_NEXT,   ST_FETCH},   // 27
        '{OP_MUL_HL,   C_NEXT,   ST_FETCH},   // 28
        '{OP_MUL_FIN,  C_NEXT,   ST_FETCH},   // 29
        '{OP_TRY,      C_REJECT, ST_LOOP},    // 30
        '{OP_DIV_RAND, C_NEXT,   ST_FETCH},   // 31
        '{OP_DIV_WAIT, C_NEXT,   ST_FETCH},   // 32
        '{OP_RES_MOD,  C_ALWAYS, ST_EMIT}     // 33
    };

    // XSH-RR output permutation of the old state
    function automatic logic [31:0] xsh_rr(input logic [63:0] s);
        logic [63:0] mix;
        logic [31:0] xs;
        logic [63:0] dbl;
        mix = ((s >> 18) ^ s) >> 27;
        xs  = mix[31:0];
        dbl = {xs, xs} >> s[63:59];
        return dbl[31:0];
    endfunction

endpackage

`default_nettype wire

### src/pcg32_bounded_random.sv
// Range request: at most 1024 draws, two remainder passes of the bit-serial divider and
// 4 multiplier steps per draw. One request at a time: the next request is taken the
// cycle after the result is loaded, and a held result stalls the load.
// Reset (synchronous, active low) clears the generator state, increment and seed registers.
`timescale 1ns / 1ps
`default_nettype none

module pcg32_bounded_random #(
    parameter int RETRY_LIMIT = pcgbr_pkg::RETRY_LIMIT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_req_valid,
    output logic                                   o_req_ready,
    input  wire logic [1:0]                        i_req_type,
    input  wire logic signed [31:0]                i_low_bound,
    input  wire logic signed [31:0]                i_high_bound,
    output logic                                   o_res_valid,
    input  wire logic                              i_res_ready,
    output logic [31:0]                            o_value,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pcgbr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [63:0]                       i_cfg_data
);

    localparam int TRIES_W = $clog2(RETRY_LIMIT);
    localparam int PC_W    = pcgbr_pkg::PC_W;

    // Sequencer
    logic [PC_W-1:0]    r_pc;
    logic [PC_W-1:0]    n_pc;
    pcgbr_pkg::t_uword  w_uw;
    logic               w_stall;
    logic               w_take;

    // Architectural state and configuration
    logic [63:0] r_state;
    logic [63:0] r_inc;
    logic [63:0] r_seed_state;
    logic [63:0] r_seed_stream;

    // Request and working registers
    logic [1:0]         r_req_type;
    logic [31:0]        r_low;
    logic [31:0]        r_high;
    logic [31:0]        r_bound;
    logic [31:0]        r_thresh;
    logic [31:0]        r_rand;
    logic [31:0]        r_result;
    logic [63:0]        r_prod;
    logic [63:0]        r_acc;
    logic [TRIES_W-1:0] r_tries;

    // Output register
    logic        r_out_valid;
    logic [31:0] r_value;

    // Multiplier and divider wiring
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_mul_p;
    logic        w_div_start;
    logic [31:0] w_div_dvd;
    logic        w_div_busy;
    logic [31:0] w_div_rem;
    logic        w_emit_fire;

    assign w_uw = pcgbr_pkg::UCODE[r_pc];

    assign o_req_ready = (w_uw.op == pcgbr_pkg::OP_FETCH);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_out_valid;
    assign o_value     = r_value;

    assign w_emit_fire = (w_uw.op == pcgbr_pkg::OP_EMIT) && (!r_out_valid || i_res_ready);

    // Hold the step while waiting on a handshake or the divider
    always_comb begin
        w_stall = 1'b0;
        unique case (w_uw.op)
            pcgbr_pkg::OP_FETCH:    w_stall = !i_req_valid;
            pcgbr_pkg::OP_EMIT:     w_stall = !w_emit_fire;
            pcgbr_pkg::OP_DIV_WAIT: w_stall = w_div_busy;
            default:                w_stall = 1'b0;
        endcase
    end

    // Evaluate the jump condition
    always_comb begin
        w_take = 1'b0;
        unique case (w_uw.cond)
            pcgbr_pkg::C_NEXT:   w_take = 1'b0;
            pcgbr_pkg::C_ALWAYS: w_take = 1'b1;
            pcgbr_pkg::C_RESEED: w_take = (r_req_type == pcgbr_pkg::REQ_RESEED);
            pcgbr_pkg::C_RAW:    w_take = (r_req_type == pcgbr_pkg::REQ_RAW);
            pcgbr_pkg::C_RANGE:  w_take = (r_req_type == pcgbr_pkg::REQ_RANGE)
                                          && (r_low != r_high);
            pcgbr_pkg::C_REJECT: w_take = (r_rand < r_thresh)
                                          && (r_tries != TRIES_W'(RETRY_LIMIT - 1));
            default:             w_take = 1'b0;
        endcase
    end

    // Advance the step counter
    always_comb begin
        if (w_stall) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= pcgbr_pkg::ST_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Shared 32x32 multiplier, operands picked by the step
    always_comb begin
        w_mul_a = r_state[31:0];
        w_mul_b = pcgbr_pkg::PCG_MULT_LO;
        unique case (w_uw.op)
            pcgbr_pkg::OP_MUL_LH: begin
                w_mul_a = r_state[31:0];
                w_mul_b = pcgbr_pkg::PCG_MULT_HI;
            end
            pcgbr_pkg::OP_MUL_HL: begin
                w_mul_a = r_state[63:32];
                w_mul_b = pcgbr_pkg::PCG_MULT_LO;
            end
            default: begin
                w_mul_a = r_state[31:0];
                w_mul_b = pcgbr_pkg::PCG_MULT_LO;
            end
        endcase
    end

    assign w_mul_p = {32'd0, w_mul_a} * {32'd0, w_mul_b};

    // Remainder unit
    assign w_div_start = (w_uw.op == pcgbr_pkg::OP_DIV_THR)
                         || (w_uw.op == pcgbr_pkg::OP_DIV_RAND);
    assign w_div_dvd   = (w_uw.op == pcgbr_pkg::OP_DIV_THR) ? (32'd0 - r_bound) : r_rand;

    pcgbr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (r_bound),
        .o_busy     (w_div_busy),
        .o_rem      (w_div_rem)
    );

    // Generator state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= '0;
            r_inc         <= '0;
            r_seed_state  <= '0;
            r_seed_stream <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    pcgbr_pkg::CFG_SEED_STATE:  r_seed_state  <= i_cfg_data;
                    pcgbr_pkg::CFG_SEED_STREAM: r_seed_stream <= i_cfg_data;
                    default: ;
                endcase
            end
            case (w_uw.op)
                pcgbr_pkg::OP_RESEED: begin
                    r_state <= '0;
                    r_inc   <= {r_seed_stream[62:0], 1'b1};
                end
                pcgbr_pkg::OP_ADD_SEED: r_state <= r_state + r_seed_state;
                pcgbr_pkg::OP_MUL_FIN:  r_state <= {r_acc[63:32] + r_prod[31:0], r_acc[31:0]};
                default: ;
            endcase
        end
    end

    // Working datapath
    always_ff @(posedge i_clk) begin
        case (w_uw.op)
            pcgbr_pkg::OP_FETCH: begin
                r_req_type <= i_req_type;
                r_low      <= i_low_bound;
                r_high     <= i_high_bound;
            end
            pcgbr_pkg::OP_MUL_LL: begin
                r_prod <= w_mul_p;
                r_rand <= pcgbr_pkg::xsh_rr(r_state);
            end
            pcgbr_pkg::OP_MUL_LH: begin
                r_acc  <= r_prod + r_inc;
                r_prod <= w_mul_p;
            end
            pcgbr_pkg::OP_MUL_HL: begin
                r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                r_prod       <= w_mul_p;
            end
            pcgbr_pkg::OP_BOUND: begin
                r_bound <= r_high - r_low;
                r_tries <= '0;
            end
            pcgbr_pkg::OP_SAVE_THR: r_thresh <= w_div_rem;
            pcgbr_pkg::OP_TRY:      r_tries  <= r_tries + 1'b1;
            pcgbr_pkg::OP_RES_TRIV: begin
                r_result <= (r_req_type == pcgbr_pkg::REQ_RANGE) ? r_low : 32'd0;
            end
            pcgbr_pkg::OP_RES_ZERO: r_result <= 32'd0;
            pcgbr_pkg::OP_RES_RAND: r_result <= r_rand;
            pcgbr_pkg::OP_RES_MOD:  r_result <= w_div_rem + r_low;
            default: ;
        endcase
    end

    // Output register: load on emit, drop valid after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_fire) begin
            r_value <= r_result;
        end
    end

endmodule

`default_nettype wire

### src/pcgbr_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pcgbr_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [pcgbr_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [pcgbr_pkg::DIV_W-1:0] i_divisor,
    output logic                           o_busy,
    output logic [pcgbr_pkg::DIV_W-1:0]    o_rem
);

    localparam int W   = pcgbr_pkg::DIV_W;
    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dvd;
    logic [W-1:0]     r_dvs;

    logic [W:0]       w_shift;
    logic [W:0]       w_diff;
    logic [W-1:0]     n_rem;

    // Shift in one dividend bit, subtract when it fits
    always_comb begin
        w_shift = {r_rem, r_dvd[W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        if (!w_diff[W]) begin
            n_rem = w_diff[W-1:0];
        end else begin
            n_rem = w_shift[W-1:0];
        end
    end

    // Control: one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[W-2:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire
